@@ sv/abq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abq_pkg
// Shared types and codes of the alternating-bit ARQ router node.
// ---------------------------------------------------------------------------
package abq_pkg;

  // Node count; must be a power of two so that an id reduces by its low bits
  localparam int NODES  = 16;
  localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;

  // Result queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Request kinds
  localparam logic [1:0] REQ_RX    = 2'd0;
  localparam logic [1:0] REQ_SEND  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_ROUTE = 2'd3;

  // Result actions
  localparam logic [2:0] ACT_DELIVER   = 3'd0;
  localparam logic [2:0] ACT_ACK       = 3'd1;
  localparam logic [2:0] ACT_FORWARD   = 3'd2;
  localparam logic [2:0] ACT_SEND      = 3'd3;
  localparam logic [2:0] ACT_CONFIRMED = 3'd4;
  localparam logic [2:0] ACT_FAILED    = 3'd5;
  localparam logic [2:0] ACT_BUSY      = 3'd6;

  // Configuration register indexes (word address)
  localparam logic [1:0] REG_OWN_ID    = 2'd0;
  localparam logic [1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [1:0] REG_MAX_TRIES = 2'd2;

  localparam logic [15:0] TIMEOUT_RST   = 16'd300;
  localparam logic [2:0]  MAX_TRIES_RST = 3'd3;

  typedef struct packed {
    logic [3:0]  own_id;
    logic [15:0] timeout_ticks;
    logic [2:0]  max_tries;
  } abq_cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  src_id;
    logic [3:0]  dst_id;
    logic        seq_bit;
    logic        is_ack;
    logic [31:0] payload;
    logic [3:0]  next_hop_in;
  } abq_item_t;

  // One queue entry; dual marks a delivery that goes out ahead of the ack.
  // For a dual entry data holds the delivered word and the ack carries zero.
  typedef struct packed {
    logic        dual;
    logic [2:0]  action;
    logic [3:0]  next_hop;
    logic [3:0]  pkt_src;
    logic [3:0]  pkt_dst;
    logic        pkt_seq;
    logic        pkt_ack;
    logic [31:0] data;
  } abq_entry_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  next_hop;
    logic [3:0]  pkt_src;
    logic [3:0]  pkt_dst;
    logic        pkt_seq;
    logic        pkt_ack;
    logic [31:0] data_out;
    logic        last;
  } abq_result_t;

  // Reduce a node id to a table index
  function automatic logic [NODE_W-1:0] node_idx(input logic [3:0] id);
    return NODE_W'(id);
  endfunction

endpackage : abq_pkg
`default_nettype wire

@@ sv/alternating_bit_arq_node_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// alternating_bit_arq_node_unit
// Stop-and-wait ARQ router node with an alternating sequence bit per peer.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | req_type, ids, seq, ack, payload, hop
//   out_    | output    | out_valid/out_stall| action, header fields, data, last
//   cfg     | input     | APB write/read     | own_id, timeout_ticks, max_tries
//
// One request is taken per cycle unless the queue is full; results leave through
// a 4-entry queue and the output register one per cycle unless out_stall holds,
// a delivered packet giving two (delivery then ack). A request is registered in
// the queue, then in the output register. Input stalls only while the queue is full.
// Reset is synchronous; route table entries are not cleared, valid once written.
// ---------------------------------------------------------------------------
module alternating_bit_arq_node_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [3:0]  in_src_id,
  input  wire logic [3:0]  in_dst_id,
  input  wire logic        in_seq_bit,
  input  wire logic        in_is_ack,
  input  wire logic [31:0] in_payload,
  input  wire logic [3:0]  in_next_hop_in,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_action,
  output logic [3:0]       out_next_hop,
  output logic [3:0]       out_pkt_src,
  output logic [3:0]       out_pkt_dst,
  output logic             out_pkt_seq,
  output logic             out_pkt_ack,
  output logic [31:0]      out_data_out,
  output logic             out_last,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import abq_pkg::*;

  abq_cfg_t    cfg_r;
  abq_item_t   item;
  abq_entry_t  push_entry, head;
  abq_result_t res;
  logic        accept, push, pop, q_full, head_valid, cfg_we;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id        <= '0;
      cfg_r.timeout_ticks <= TIMEOUT_RST;
      cfg_r.max_tries     <= MAX_TRIES_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_OWN_ID:    cfg_r.own_id        <= pwdata[3:0];
        REG_TIMEOUT:   cfg_r.timeout_ticks <= pwdata[15:0];
        REG_MAX_TRIES: cfg_r.max_tries     <= pwdata[2:0];
        default:       cfg_r.own_id        <= cfg_r.own_id;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      REG_OWN_ID:    prdata = {28'd0, cfg_r.own_id};
      REG_TIMEOUT:   prdata = {16'd0, cfg_r.timeout_ticks};
      REG_MAX_TRIES: prdata = {29'd0, cfg_r.max_tries};
      default:       prdata = '0;
    endcase
  end

  // Request intake
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign item.req_type    = in_req_type;
  assign item.src_id      = in_src_id;
  assign item.dst_id      = in_dst_id;
  assign item.seq_bit     = in_seq_bit;
  assign item.is_ack      = in_is_ack;
  assign item.payload     = in_payload;
  assign item.next_hop_in = in_next_hop_in;

  abq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (accept),
    .item       (item),
    .push       (push),
    .push_entry (push_entry)
  );

  abq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  abq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  // Unpack the result
  assign out_action   = res.action;
  assign out_next_hop = res.next_hop;
  assign out_pkt_src  = res.pkt_src;
  assign out_pkt_dst  = res.pkt_dst;
  assign out_pkt_seq  = res.pkt_seq;
  assign out_pkt_ack  = res.pkt_ack;
  assign out_data_out = res.data_out;
  assign out_last     = res.last;

endmodule : alternating_bit_arq_node_unit
`default_nettype wire

@@ sv/abq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abq_front
// Accepts requests, updates the ARQ state and classifies each request into
// one queue entry (or none).
// ---------------------------------------------------------------------------
module abq_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire abq_pkg::abq_cfg_t  cfg,
  input  wire logic               accept,
  input  wire abq_pkg::abq_item_t item,
  output logic                    push,
  output abq_pkg::abq_entry_t     push_entry
);
  import abq_pkg::*;

  logic [NODES-1:0]  exp_bits_r, exp_bits_nxt;
  logic [NODES-1:0]  send_bits_r, send_bits_nxt;
  logic [3:0]        route_r [NODES];
  logic              route_we;
  logic [NODE_W-1:0] route_wa;
  logic              waiting_r, waiting_nxt;
  logic [3:0]        pend_dst_r, pend_dst_nxt;
  logic [31:0]       pend_pay_r, pend_pay_nxt;
  logic [2:0]        tries_r, tries_nxt;
  logic [15:0]       timer_r, timer_nxt;

  logic [NODE_W-1:0] src_ix, dst_ix, pd_ix, rd_ix;
  logic [3:0]        hop;
  logic [15:0]       arm_val;
  logic [2:0]        try_lim;
  logic              pd_bit;

  assign src_ix  = node_idx(item.src_id);
  assign dst_ix  = node_idx(item.dst_id);
  assign pd_ix   = node_idx(pend_dst_r);
  assign pd_bit  = send_bits_r[pd_ix];
  assign arm_val = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
  assign try_lim = (cfg.max_tries == 3'd0) ? 3'd1 : cfg.max_tries;

  // Pick the single route table read address for this request
  always_comb begin
    rd_ix = dst_ix;
    case (item.req_type)
      REQ_RX:   rd_ix = (item.dst_id == cfg.own_id) ? src_ix : dst_ix;
      REQ_TICK: rd_ix = pd_ix;
      default:  rd_ix = dst_ix;
    endcase
  end
  assign hop = route_r[rd_ix];

  // Classify the request and compute the next state
  always_comb begin
    exp_bits_nxt  = exp_bits_r;
    send_bits_nxt = send_bits_r;
    waiting_nxt   = waiting_r;
    pend_dst_nxt  = pend_dst_r;
    pend_pay_nxt  = pend_pay_r;
    tries_nxt     = tries_r;
    timer_nxt     = timer_r;
    route_we      = 1'b0;
    route_wa      = dst_ix;
    push          = 1'b0;
    push_entry    = '0;
    if (accept) begin
      case (item.req_type)
        REQ_RX: begin
          if (item.dst_id == cfg.own_id) begin
            if (!item.is_ack) begin
              // Deliver on a matching bit, acknowledge always
              push                = 1'b1;
              push_entry.dual     = (exp_bits_r[src_ix] == item.seq_bit);
              push_entry.action   = ACT_ACK;
              push_entry.next_hop = hop;
              push_entry.pkt_src  = cfg.own_id;
              push_entry.pkt_dst  = item.src_id;
              push_entry.pkt_seq  = item.seq_bit;
              push_entry.pkt_ack  = 1'b1;
              push_entry.data     = (exp_bits_r[src_ix] == item.seq_bit) ?
                                    item.payload : 32'd0;
              if (exp_bits_r[src_ix] == item.seq_bit) begin
                exp_bits_nxt[src_ix] = ~exp_bits_r[src_ix];
              end
            end else if (waiting_r && item.src_id == pend_dst_r &&
                         item.seq_bit == pd_bit) begin
              // Matching ack confirms the pending send
              push                = 1'b1;
              push_entry.action   = ACT_CONFIRMED;
              push_entry.pkt_src  = cfg.own_id;
              push_entry.pkt_dst  = pend_dst_r;
              push_entry.pkt_seq  = pd_bit;
              push_entry.data     = pend_pay_r;
              send_bits_nxt[pd_ix] = ~pd_bit;
              waiting_nxt         = 1'b0;
              timer_nxt           = '0;
            end
          end else begin
            // Forward through the route table
            push                = 1'b1;
            push_entry.action   = ACT_FORWARD;
            push_entry.next_hop = hop;
            push_entry.pkt_src  = item.src_id;
            push_entry.pkt_dst  = item.dst_id;
            push_entry.pkt_seq  = item.seq_bit;
            push_entry.pkt_ack  = item.is_ack;
            push_entry.data     = item.payload;
          end
        end
        REQ_SEND: begin
          push               = 1'b1;
          push_entry.pkt_src = cfg.own_id;
          push_entry.pkt_dst = item.dst_id;
          push_entry.data    = item.payload;
          if (waiting_r) begin
            push_entry.action = ACT_BUSY;
          end else begin
            push_entry.action   = ACT_SEND;
            push_entry.next_hop = hop;
            push_entry.pkt_seq  = send_bits_r[dst_ix];
            waiting_nxt         = 1'b1;
            pend_dst_nxt        = item.dst_id;
            pend_pay_nxt        = item.payload;
            tries_nxt           = 3'd1;
            timer_nxt           = arm_val;
          end
        end
        REQ_TICK: begin
          if (waiting_r) begin
            if (timer_r > 16'd1) begin
              timer_nxt = timer_r - 16'd1;
            end else begin
              push               = 1'b1;
              push_entry.pkt_src = cfg.own_id;
              push_entry.pkt_dst = pend_dst_r;
              push_entry.pkt_seq = pd_bit;
              push_entry.data    = pend_pay_r;
              if (tries_r >= try_lim) begin
                push_entry.action = ACT_FAILED;
                waiting_nxt       = 1'b0;
                timer_nxt         = '0;
              end else begin
                push_entry.action   = ACT_SEND;
                push_entry.next_hop = hop;
                tries_nxt           = tries_r + 3'd1;
                timer_nxt           = arm_val;
              end
            end
          end
        end
        REQ_ROUTE: begin
          route_we = 1'b1;
          route_wa = dst_ix;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // Hold the ARQ control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_bits_r  <= '0;
      send_bits_r <= '0;
      waiting_r   <= 1'b0;
      pend_dst_r  <= '0;
      pend_pay_r  <= '0;
      tries_r     <= '0;
      timer_r     <= '0;
    end else begin
      exp_bits_r  <= exp_bits_nxt;
      send_bits_r <= send_bits_nxt;
      waiting_r   <= waiting_nxt;
      pend_dst_r  <= pend_dst_nxt;
      pend_pay_r  <= pend_pay_nxt;
      tries_r     <= tries_nxt;
      timer_r     <= timer_nxt;
    end
  end

  // Write the route table; no reset, entries are defined once written
  always_ff @(posedge clk) begin
    if (route_we) begin
      route_r[route_wa] <= item.next_hop_in;
    end
  end

  // Waiting drops only on an accepted request
  a_wait_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(waiting_r) |-> $past(accept))
    else $error("waiting cleared without a request");

  // Results come only from accepted requests
  a_push_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> accept)
    else $error("queue push without an accepted request");

endmodule : abq_front
`default_nettype wire

@@ sv/abq_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abq_queue
// Short register queue of classified entries between front and back.
// ---------------------------------------------------------------------------
module abq_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire abq_pkg::abq_entry_t push_entry,
  input  wire logic                pop,
  output logic                     full,
  output logic                     head_valid,
  output abq_pkg::abq_entry_t      head
);
  import abq_pkg::*;

  abq_entry_t    mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, wr_nxt;
  logic [Q_AW-1:0] rd_r, rd_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full       = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and fill count
  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("push into a full queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count out of range");

endmodule : abq_queue
`default_nettype wire

@@ sv/abq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abq_back
// Expands queue entries into result requests and holds them in the output
// register until taken.
// ---------------------------------------------------------------------------
module abq_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                head_valid,
  input  wire abq_pkg::abq_entry_t head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output abq_pkg::abq_result_t     out_res
);
  import abq_pkg::*;

  logic        out_valid_r;
  abq_result_t res_r, res_nxt;
  logic        phase_r, phase_nxt;
  logic        load;

  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && (!head.dual || phase_r);

  // Build the next result: delivery half first for a dual entry
  always_comb begin
    res_nxt   = res_r;
    phase_nxt = phase_r;
    if (load) begin
      if (head.dual && !phase_r) begin
        res_nxt.action   = ACT_DELIVER;
        res_nxt.next_hop = '0;
        res_nxt.pkt_src  = head.pkt_dst;
        res_nxt.pkt_dst  = head.pkt_src;
        res_nxt.pkt_seq  = head.pkt_seq;
        res_nxt.pkt_ack  = 1'b0;
        res_nxt.data_out = head.data;
        res_nxt.last     = 1'b0;
        phase_nxt        = 1'b1;
      end else begin
        res_nxt.action   = head.action;
        res_nxt.next_hop = head.next_hop;
        res_nxt.pkt_src  = head.pkt_src;
        res_nxt.pkt_dst  = head.pkt_dst;
        res_nxt.pkt_seq  = head.pkt_seq;
        res_nxt.pkt_ack  = head.pkt_ack;
        res_nxt.data_out = head.dual ? 32'd0 : head.data;
        res_nxt.last     = 1'b1;
        phase_nxt        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= head_valid;
      end
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // The second half of a dual entry waits behind a shown delivery
  a_phase_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (out_valid_r && res_r.action == ACT_DELIVER && !res_r.last))
    else $error("split entry without a shown delivery");

endmodule : abq_back
`default_nettype wire
